### src/srh_pkg.sv
// Shared types and constants for the sequential run histogram.
// Used by every module of the block; depends on nothing else.
`timescale 1ns / 1ps

package srh_pkg;

    // Action codes carried on the input channel.
    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_CLOSE = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    localparam int ACTION_W   = 2;
    localparam int START_W    = 48;
    localparam int COUNT_W    = 16;
    localparam int BIN_PORT_W = 10;
    localparam int TALLY_W    = 32;
    localparam int TOTAL_W    = 48;
    // Widest histogram address the block supports (65536 bins).
    localparam int REQ_BIN_W  = 16;

    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    // Result queue in front of the output channel.
    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = 2;
    localparam int OUTQ_CNT_W = 3;

    // One histogram access issued by the run tracker.
    typedef struct packed {
        logic                  rec;        // increment a bin
        logic                  rd;         // read a bin back
        logic [REQ_BIN_W-1:0]  bin;
        logic                  in_range;
        logic [BIN_PORT_W-1:0] bin_number;
        logic [TOTAL_W-1:0]    total;
    } t_hist_req;

    typedef struct packed {
        logic [BIN_PORT_W-1:0] bin_number;
        logic [TALLY_W-1:0]    tally;
        logic [TOTAL_W-1:0]    total;
    } t_result;

endpackage

### src/srh_tracker.sv
// Run tracker: follows sequential write runs and the block total, and issues
// histogram accesses. Depends on srh_pkg.
`timescale 1ns / 1ps

module srh_tracker import srh_pkg::*; #(
    parameter int HIST_BINS = 1024,
    parameter int ADDR_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [START_W-1:0]    i_start_block,
    input  logic [COUNT_W-1:0]    i_block_count,
    input  logic [BIN_PORT_W-1:0] i_bin_select,
    output t_hist_req             o_req
);

    logic                 r_seen_any, n_seen_any;
    logic [ADDR_BITS-1:0] r_next_start, n_next_start;
    logic [TALLY_W-1:0]   r_open_run, n_open_run;
    logic [TOTAL_W-1:0]   r_block_total, n_block_total;

    logic [63:0]          w_start64;
    logic [63:0]          w_count64;
    logic [ADDR_BITS-1:0] w_start;
    logic [ADDR_BITS-1:0] w_count;
    logic                 w_contig;
    logic [TALLY_W:0]     w_open_sum;
    logic [TOTAL_W:0]     w_total_sum;
    logic [REQ_BIN_W-1:0] w_run_bin;
    logic [31:0]          w_sel32;

    assign w_start64 = {16'd0, i_start_block};
    assign w_count64 = {48'd0, i_block_count};
    assign w_start   = w_start64[ADDR_BITS-1:0];
    assign w_count   = w_count64[ADDR_BITS-1:0];
    assign w_contig  = r_seen_any && (w_start == r_next_start);

    assign w_open_sum  = {1'b0, r_open_run} + {17'd0, i_block_count};
    assign w_total_sum = {1'b0, r_block_total} + {33'd0, i_block_count};

    // Runs at or beyond the top bin all land in it.
    assign w_run_bin = (r_open_run >= 32'(HIST_BINS - 1)) ? REQ_BIN_W'(HIST_BINS - 1)
                                                          : r_open_run[REQ_BIN_W-1:0];
    assign w_sel32   = {22'd0, i_bin_select};

    always_comb begin
        n_seen_any    = r_seen_any;
        n_next_start  = r_next_start;
        n_open_run    = r_open_run;
        n_block_total = r_block_total;
        o_req            = '0;
        o_req.total      = r_block_total;
        o_req.bin_number = i_bin_select;
        o_req.bin        = w_run_bin;
        if (i_fire) begin
            case (i_action)
                ACT_WRITE: begin
                    n_seen_any   = 1'b1;
                    n_next_start = w_start + w_count;
                    if (w_contig) begin
                        n_open_run = w_open_sum[TALLY_W] ? TALLY_MAX : w_open_sum[TALLY_W-1:0];
                    end else begin
                        // A break records the finished run, even an empty one.
                        o_req.rec  = r_seen_any;
                        n_open_run = {16'd0, i_block_count};
                    end
                    n_block_total = w_total_sum[TOTAL_W] ? TOTAL_MAX
                                                         : w_total_sum[TOTAL_W-1:0];
                end
                ACT_CLOSE: begin
                    o_req.rec  = (r_open_run != '0);
                    n_open_run = '0;
                    n_seen_any = 1'b0;
                end
                ACT_READ: begin
                    o_req.rd       = 1'b1;
                    o_req.bin      = w_sel32[REQ_BIN_W-1:0];
                    o_req.in_range = (w_sel32 < 32'(HIST_BINS));
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen_any    <= 1'b0;
            r_next_start  <= '0;
            r_open_run    <= '0;
            r_block_total <= '0;
        end else begin
            r_seen_any    <= n_seen_any;
            r_next_start  <= n_next_start;
            r_open_run    <= n_open_run;
            r_block_total <= n_block_total;
        end
    end

endmodule

### src/srh_hist.sv
// Histogram memory with its read-modify-write stage, write forwarding and the
// clearing pass after reset. Depends on srh_pkg.
`timescale 1ns / 1ps

module srh_hist import srh_pkg::*; #(
    parameter int HIST_BINS = 1024
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_hist_req i_req,
    output logic      o_busy,
    output logic      o_s1_rd,
    output logic      o_push,
    output t_result   o_push_data
);

    localparam int BIN_W = $clog2(HIST_BINS);

    logic [TALLY_W-1:0] r_mem [HIST_BINS];
    logic [TALLY_W-1:0] r_rd_data;

    logic             r_clr_active;
    logic [BIN_W-1:0] r_clr_addr;

    logic             r_s1_rec;
    logic             r_s1_rd;
    logic [BIN_W-1:0] r_s1_addr;
    t_hist_req        r_s1_req;

    logic               r_fw_valid;
    logic [BIN_W-1:0]   r_fw_addr;
    logic [TALLY_W-1:0] r_fw_data;

    logic [BIN_W-1:0]   w_raddr;
    logic [TALLY_W-1:0] w_cur;
    logic [TALLY_W-1:0] w_inc;
    logic               w_we;
    logic [BIN_W-1:0]   w_waddr;
    logic [TALLY_W-1:0] w_wdata;

    assign w_raddr = i_req.bin[BIN_W-1:0];

    // The memory returns the old value when the previous cycle wrote the
    // same bin, so that write is forwarded here.
    assign w_cur = (r_fw_valid && (r_fw_addr == r_s1_addr)) ? r_fw_data : r_rd_data;
    assign w_inc = (w_cur == TALLY_MAX) ? w_cur : w_cur + 1'b1;

    assign w_we    = r_clr_active || r_s1_rec;
    assign w_waddr = r_clr_active ? r_clr_addr : r_s1_addr;
    assign w_wdata = r_clr_active ? '0 : w_inc;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (i_req.rec || i_req.rd) begin
            r_rd_data <= r_mem[w_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_active <= 1'b1;
            r_clr_addr   <= '0;
            r_s1_rec     <= 1'b0;
            r_s1_rd      <= 1'b0;
            r_fw_valid   <= 1'b0;
        end else begin
            if (r_clr_active) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == BIN_W'(HIST_BINS - 1)) begin
                    r_clr_active <= 1'b0;
                end
            end
            r_s1_rec   <= i_req.rec;
            r_s1_rd    <= i_req.rd;
            r_fw_valid <= r_s1_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_addr <= w_raddr;
        r_s1_req  <= i_req;
        r_fw_addr <= r_s1_addr;
        r_fw_data <= w_inc;
    end

    assign o_busy  = r_clr_active;
    assign o_s1_rd = r_s1_rd;
    assign o_push  = r_s1_rd;

    assign o_push_data.bin_number = r_s1_req.bin_number;
    assign o_push_data.tally      = r_s1_req.in_range ? w_cur : '0;
    assign o_push_data.total      = r_s1_req.total;

endmodule

### src/srh_outq.sv
// Small result queue that decouples the histogram stage from the output
// channel. Depends on srh_pkg.
`timescale 1ns / 1ps

module srh_outq import srh_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_result               i_push_data,
    input  logic                  i_pop,
    output logic                  o_valid,
    output t_result               o_data,
    output logic [OUTQ_CNT_W-1:0] o_count
);

    t_result               r_buf [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wr_ptr;
    logic [OUTQ_PTR_W-1:0] r_rd_ptr;
    logic [OUTQ_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_push_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_buf[r_rd_ptr];
    assign o_count = r_count;

endmodule

### src/sequential_run_histogram.sv
// Sequential write-run histogram: one input transaction per clock cycle, in
// any mix of writes, closes and reads. A read result is registered in the
// histogram stage and then written into a four-entry queue, from which results
// leave in order; the input stalls only while the memory is cleared or when
// that queue and the histogram stage could not hold one more result. The rate
// is set by the single read-modify-write stage on the histogram memory, which
// forwards its own last write. After reset the memory is cleared one bin per
// cycle, so the input is not ready until every bin has been cleared.
// Depends on srh_pkg, srh_tracker, srh_hist and srh_outq.
`timescale 1ns / 1ps

module sequential_run_histogram import srh_pkg::*; #(
    parameter int HIST_BINS = 1024,
    parameter int ADDR_BITS = 48
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  logic [ACTION_W-1:0]   i_action,
    input  logic [START_W-1:0]    i_start_block,
    input  logic [COUNT_W-1:0]    i_block_count,
    input  logic [BIN_PORT_W-1:0] i_bin_select,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [BIN_PORT_W-1:0] o_bin_number,
    output logic [TALLY_W-1:0]    o_run_tally,
    output logic [TOTAL_W-1:0]    o_blocks_written
);

    t_hist_req             w_req;
    t_result               w_push_data;
    t_result               w_head;
    logic                  w_fire;
    logic                  w_busy;
    logic                  w_s1_rd;
    logic                  w_push;
    logic                  w_pop;
    logic [OUTQ_CNT_W-1:0] w_q_count;
    logic [OUTQ_CNT_W:0]   w_pending;

    // Results still owed count against queue space before a new transaction enters.
    assign w_pending  = {1'b0, w_q_count} + {{OUTQ_CNT_W{1'b0}}, w_s1_rd};
    assign o_in_ready = !w_busy && (w_pending < (OUTQ_CNT_W + 1)'(OUTQ_DEPTH));
    assign w_fire     = i_in_valid && o_in_ready;
    assign w_pop      = o_out_valid && i_out_ready;

    srh_tracker #(
        .HIST_BINS (HIST_BINS),
        .ADDR_BITS (ADDR_BITS)
    ) u_tracker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_fire        (w_fire),
        .i_action      (i_action),
        .i_start_block (i_start_block),
        .i_block_count (i_block_count),
        .i_bin_select  (i_bin_select),
        .o_req         (w_req)
    );

    srh_hist #(
        .HIST_BINS (HIST_BINS)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (w_req),
        .o_busy      (w_busy),
        .o_s1_rd     (w_s1_rd),
        .o_push      (w_push),
        .o_push_data (w_push_data)
    );

    srh_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .i_pop       (w_pop),
        .o_valid     (o_out_valid),
        .o_data      (w_head),
        .o_count     (w_q_count)
    );

    assign o_bin_number     = w_head.bin_number;
    assign o_run_tally      = w_head.tally;
    assign o_blocks_written = w_head.total;

endmodule

### src/srh_checker.sv
// Port-level checks for the sequential run histogram, attached by bind.
// Depends on srh_pkg and the sequential_run_histogram top level.
`timescale 1ns / 1ps

module srh_checker import srh_pkg::*; #(
    parameter int HIST_BINS = 1024
) (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input logic [BIN_PORT_W-1:0] o_bin_number,
    input logic [TALLY_W-1:0]    o_run_tally,
    input logic [TOTAL_W-1:0]    o_blocks_written
);

    // Reset empties the result queue.
    a_reset_empties: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // The clearing pass holds the input off when reset is released.
    a_clear_blocks_input: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("input ready during histogram clearing");

    // A bin that does not exist always reads back as zero.
    a_missing_bin_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (32'(o_bin_number) >= 32'(HIST_BINS))) |-> (o_run_tally == '0))
        else $error("nonzero tally for a bin beyond the histogram");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_bin_number) && $stable(o_run_tally)
             && $stable(o_blocks_written)))
        else $error("output payload changed while stalled");

endmodule

bind sequential_run_histogram srh_checker #(
    .HIST_BINS (HIST_BINS)
) u_srh_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_in_valid),
    .o_in_ready       (o_in_ready),
    .o_out_valid      (o_out_valid),
    .i_out_ready      (i_out_ready),
    .o_bin_number     (o_bin_number),
    .o_run_tally      (o_run_tally),
    .o_blocks_written (o_blocks_written)
);
